// ----- sv/pta_pkg.sv -----
// Shared types, constants and angle arithmetic for the pose transition blend.
// Used by pta_front, pta_ease, pta_back and pose_transition_angle_blend.
package pta_pkg;

   localparam int ANGLE_W = 12;
   localparam int JOINT_W = 6;
   localparam int TAG_W   = 16;
   localparam int TIME_W  = 16;
   localparam int CLOCK_W = 17;
   localparam int EASE_W  = 17;

   localparam logic [EASE_W-1:0]  ONE_Q16   = 17'h10000;
   localparam logic [CLOCK_W-1:0] CLOCK_MAX = 17'h1FFFF;
   localparam logic [ANGLE_W-1:0] HALF_TURN = 12'd2048;
   localparam logic [17:0]        EASE_K3   = 18'd196608;

   typedef struct packed {
      logic [JOINT_W-1:0] joint_index;
      logic [ANGLE_W-1:0] angle_x;
      logic [ANGLE_W-1:0] angle_y;
      logic [ANGLE_W-1:0] angle_z;
      logic [TAG_W-1:0]   sequence_tag;
      logic [TAG_W-1:0]   motion_id;
      logic [TIME_W-1:0]  elapsed_time;
      logic [TIME_W-1:0]  blend_duration;
      logic               is_frame;
   } item_type;

   typedef struct packed {
      logic [JOINT_W-1:0] out_joint;
      logic [ANGLE_W-1:0] out_x;
      logic [ANGLE_W-1:0] out_y;
      logic [ANGLE_W-1:0] out_z;
      logic               blending;
      logic [TAG_W-1:0]   transition_count;
   } result_type;

   typedef enum logic [2:0] {
      B_IDLE, B_FRAME, B_SWEEP, B_EASE, B_WAIT, B_READ, B_MIX
   } back_state_type;

   typedef enum logic [1:0] {
      E_IDLE, E_DIV, E_SQR, E_CUBE
   } ease_state_type;

   function automatic logic [ANGLE_W-1:0] mix_angle(input logic [ANGLE_W-1:0] from,
                                                   input logic [ANGLE_W-1:0] to,
                                                   input logic [EASE_W-1:0]  w);
      logic [ANGLE_W-1:0] d;
      logic [ANGLE_W-1:0] mag;
      logic               neg;
      logic [28:0]        prod;
      logic [ANGLE_W-1:0] r;
      d    = to - from + HALF_TURN;
      neg  = ~d[ANGLE_W-1];
      mag  = neg ? (HALF_TURN - d) : (d - HALF_TURN);
      prod = 29'(mag) * 29'(w);
      r    = ANGLE_W'((prod + 29'd32768) >> 16);
      return neg ? (from - r) : (from + r);
   endfunction

endpackage

// ----- sv/pta_front.sv -----
// Input side: accepts items, tags frame starts and queues them two deep.
// Depends on pta_pkg.
module pta_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [pta_pkg::JOINT_W-1:0]      req_joint_index,
   input  logic [pta_pkg::ANGLE_W-1:0]      req_angle_x,
   input  logic [pta_pkg::ANGLE_W-1:0]      req_angle_y,
   input  logic [pta_pkg::ANGLE_W-1:0]      req_angle_z,
   input  logic [pta_pkg::TAG_W-1:0]        req_sequence_tag,
   input  logic [pta_pkg::TAG_W-1:0]        req_motion_id,
   input  logic [pta_pkg::TIME_W-1:0]       req_elapsed_time,
   input  logic [pta_pkg::TIME_W-1:0]       req_blend_duration,
   output pta_pkg::item_type                head,
   output logic                             head_valid,
   input  logic                             pop
);
   import pta_pkg::*;

   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   incoming;
   logic       push;

   assign req_ready  = (count_ff != 2'd2);
   assign push       = req_valid && req_ready;
   assign head       = q_ff[rd_ptr_ff];
   assign head_valid = (count_ff != 2'd0);

   always_comb begin
      incoming.joint_index    = req_joint_index;
      incoming.angle_x        = req_angle_x;
      incoming.angle_y        = req_angle_y;
      incoming.angle_z        = req_angle_z;
      incoming.sequence_tag   = req_sequence_tag;
      incoming.motion_id      = req_motion_id;
      incoming.elapsed_time   = req_elapsed_time;
      incoming.blend_duration = req_blend_duration;
      incoming.is_frame       = (req_joint_index == '0);
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

// ----- sv/pta_ease.sv -----
// Ease unit: fraction clock/duration by restoring division, then smoothstep.
// Depends on pta_pkg.
module pta_ease (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pta_pkg::CLOCK_W-1:0]   clock_time,
   input  logic [pta_pkg::TIME_W-1:0]    duration,
   output logic                          done,
   output logic [pta_pkg::EASE_W-1:0]    ease
);
   import pta_pkg::*;

   ease_state_type state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [16:0] rem_ff, rem_in;
   logic [16:0] num_ff, num_in;
   logic [16:0] den_ff, den_in;
   logic [16:0] q_ff, q_in;
   logic [33:0] sq_ff, sq_in;
   logic [EASE_W-1:0] ease_ff, ease_in;
   logic [17:0] rem2;
   logic        fits;
   logic [17:0] k;
   logic [51:0] cube;

   assign rem2 = {rem_ff, num_ff[16]};
   assign fits = (rem2 >= {1'b0, den_ff});
   assign k    = EASE_K3 - {q_ff, 1'b0};
   assign cube = 52'(sq_ff) * 52'(k) + 52'h80000000;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         E_IDLE: if (start) state_in = E_DIV;
         E_DIV:  if (cnt_ff == 5'd16) state_in = E_SQR;
         E_SQR:  state_in = E_CUBE;
         E_CUBE: state_in = E_IDLE;
         default: state_in = E_IDLE;
      endcase
   end

   always_comb begin
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      sq_in   = sq_ff;
      ease_in = ease_ff;
      done    = 1'b0;
      case (state_ff)
         E_IDLE: begin
            cnt_in = 5'd0;
            rem_in = clock_time;
            num_in = {1'b0, duration};
            den_in = {duration, 1'b0};
            q_in   = '0;
         end
         E_DIV: begin
            cnt_in = cnt_ff + 5'd1;
            num_in = {num_ff[15:0], 1'b0};
            rem_in = fits ? 17'(rem2 - {1'b0, den_ff}) : rem2[16:0];
            q_in   = {q_ff[15:0], fits};
         end
         E_SQR: begin
            sq_in = 34'(q_ff) * 34'(q_ff);
         end
         E_CUBE: begin
            ease_in = cube[48:32];
            done    = 1'b1;
         end
         default: ;
      endcase
   end

   assign ease = ease_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      q_ff    <= q_in;
      sq_ff   <= sq_in;
      ease_ff <= ease_in;
   end

endmodule

// ----- sv/pta_back.sv -----
// Execution side: frame decisions, pose memories, start-pose copy and angle mix.
// Depends on pta_pkg and pta_ease.
module pta_back #(
   parameter int JOINTS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pta_pkg::item_type    head,
   input  logic                 head_valid,
   output logic                 pop,
   output pta_pkg::result_type  res,
   output logic                 res_valid,
   input  logic                 res_ready
);
   import pta_pkg::*;

   localparam int AW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
   localparam int CW = $clog2(JOINTS + 1);
   localparam int PW = 3 * ANGLE_W;

   back_state_type state_ff, state_in;
   item_type       cur_ff;
   logic           started_ff;
   logic [TAG_W-1:0]   last_seq_ff, last_mot_ff;
   logic [CLOCK_W-1:0] time_ff;
   logic [EASE_W-1:0]  ease_w_ff;
   logic [TAG_W-1:0]   trans_ff;
   logic [CW-1:0]      cnt_ff;
   logic [CW-1:0]      cnt_m1;

   logic [PW-1:0] out_mem [JOINTS];
   logic [PW-1:0] st_mem  [JOINTS];
   logic [PW-1:0] op_rd_ff;
   logic [PW-1:0] st_rd_ff;

   logic          st_rd;
   logic [AW-1:0] st_addr;
   logic          changed;
   logic          dur_zero;
   logic [17:0]   tsum;
   logic          time_ge;
   logic          ease_start, ease_done;
   logic [EASE_W-1:0] ease_out;
   logic          in_range, do_blend, do_write;
   logic [ANGLE_W-1:0] mx, my, mz;
   logic          sweep_end;

   assign dur_zero  = (cur_ff.blend_duration == '0);
   assign changed   = (cur_ff.sequence_tag != last_seq_ff) || (cur_ff.motion_id != last_mot_ff);
   assign tsum      = {1'b0, time_ff} + 18'(cur_ff.elapsed_time);
   assign time_ge   = (time_ff >= {1'b0, cur_ff.blend_duration});
   assign sweep_end = (cnt_ff == CW'(JOINTS));
   assign cnt_m1    = cnt_ff - CW'(1);
   assign in_range  = ({1'b0, cur_ff.joint_index} < 7'(JOINTS));
   assign do_write  = started_ff && in_range;
   assign do_blend  = do_write && !ease_w_ff[EASE_W-1];

   pta_ease u_ease (
      .clock      (clock),
      .reset      (reset),
      .start      (ease_start),
      .clock_time (time_ff),
      .duration   (cur_ff.blend_duration),
      .done       (ease_done),
      .ease       (ease_out)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE:  if (head_valid) state_in = head.is_frame ? B_FRAME : B_MIX;
         B_FRAME: begin
            if (dur_zero) state_in = B_READ;
            else if (started_ff && changed) state_in = B_SWEEP;
            else state_in = B_EASE;
         end
         B_SWEEP: if (sweep_end) state_in = B_EASE;
         B_EASE:  state_in = time_ge ? B_READ : B_WAIT;
         B_WAIT:  if (ease_done) state_in = B_READ;
         B_READ:  state_in = B_MIX;
         B_MIX:   if (res_ready) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      pop        = (state_ff == B_IDLE) && head_valid;
      st_rd      = pop || (state_ff == B_READ);
      ease_start = (state_ff == B_EASE) && !time_ge;
      res_valid  = (state_ff == B_MIX);
      st_addr    = (state_ff == B_IDLE) ? head.joint_index[AW-1:0]
                                        : cur_ff.joint_index[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= B_IDLE;
         started_ff  <= 1'b0;
         last_seq_ff <= '0;
         last_mot_ff <= '0;
         time_ff     <= '0;
         ease_w_ff   <= ONE_Q16;
         trans_ff    <= '0;
         cnt_ff      <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            B_FRAME: begin
               cnt_ff <= '0;
               if (dur_zero) begin
                  started_ff <= 1'b0;
                  ease_w_ff  <= ONE_Q16;
               end else if (!started_ff) begin
                  last_seq_ff <= cur_ff.sequence_tag;
                  last_mot_ff <= cur_ff.motion_id;
                  time_ff     <= {1'b0, cur_ff.blend_duration};
                  started_ff  <= 1'b1;
               end else if (changed) begin
                  last_seq_ff <= cur_ff.sequence_tag;
                  last_mot_ff <= cur_ff.motion_id;
                  time_ff     <= '0;
                  trans_ff    <= trans_ff + TAG_W'(1);
               end else begin
                  time_ff <= tsum[17] ? CLOCK_MAX : tsum[16:0];
               end
            end
            B_SWEEP: cnt_ff <= cnt_ff + CW'(1);
            B_EASE:  if (time_ge) ease_w_ff <= ONE_Q16;
            B_WAIT:  if (ease_done) ease_w_ff <= ease_out;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head;
      end
   end

   always_ff @(posedge clock) begin
      if (st_rd) begin
         st_rd_ff <= st_mem[st_addr];
      end
      if ((state_ff == B_SWEEP) && (cnt_ff != '0)) begin
         st_mem[cnt_m1[AW-1:0]] <= op_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == B_SWEEP) && !sweep_end) begin
         op_rd_ff <= out_mem[cnt_ff[AW-1:0]];
      end
      if ((state_ff == B_MIX) && res_ready && do_write) begin
         out_mem[cur_ff.joint_index[AW-1:0]] <= {mz, my, mx};
      end
   end

   always_comb begin
      if (do_blend) begin
         mx = mix_angle(st_rd_ff[ANGLE_W-1:0], cur_ff.angle_x, ease_w_ff);
         my = mix_angle(st_rd_ff[2*ANGLE_W-1:ANGLE_W], cur_ff.angle_y, ease_w_ff);
         mz = mix_angle(st_rd_ff[PW-1:2*ANGLE_W], cur_ff.angle_z, ease_w_ff);
      end else begin
         mx = cur_ff.angle_x;
         my = cur_ff.angle_y;
         mz = cur_ff.angle_z;
      end
      res.out_joint        = cur_ff.joint_index;
      res.out_x            = mx;
      res.out_y            = my;
      res.out_z            = mz;
      res.blending         = do_blend;
      res.transition_count = trans_ff;
   end

endmodule

// ----- sv/pose_transition_angle_blend.sv -----
// Pose transition crossfade of 12-bit wrapped joint angles, one joint per item.
// Input channel req_*: one joint per item; joint 0 carries the frame-wide
// sequence, motion, elapsed time and duration. Result channel rsp_*: one
// result per item, in order, held in an output register until taken.
// A two-entry queue sits between the input and the execution engine.
// A joint item other than joint 0 is popped from the queue, mixed and then
// registered in the output register; the engine pops no new item until the
// output register has taken its result. A joint-0 item adds a frame update
// (with an ease check for a nonzero duration), a copy of the last output pose
// into the start pose on a transition, and the ease fraction (17-step divider,
// then square and cube stages) while a blend is running.
// Reset clears the frame history; the first frame passes straight through.
// When rsp_ready is low the result register holds, the engine stops after
// its current item and the queue fills; req_ready falls once the queue is full.
module pose_transition_angle_blend #(
   parameter int JOINTS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [pta_pkg::JOINT_W-1:0]   req_joint_index,
   input  logic [pta_pkg::ANGLE_W-1:0]   req_angle_x,
   input  logic [pta_pkg::ANGLE_W-1:0]   req_angle_y,
   input  logic [pta_pkg::ANGLE_W-1:0]   req_angle_z,
   input  logic [pta_pkg::TAG_W-1:0]     req_sequence_tag,
   input  logic [pta_pkg::TAG_W-1:0]     req_motion_id,
   input  logic [pta_pkg::TIME_W-1:0]    req_elapsed_time,
   input  logic [pta_pkg::TIME_W-1:0]    req_blend_duration,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pta_pkg::JOINT_W-1:0]   rsp_out_joint,
   output logic [pta_pkg::ANGLE_W-1:0]   rsp_out_x,
   output logic [pta_pkg::ANGLE_W-1:0]   rsp_out_y,
   output logic [pta_pkg::ANGLE_W-1:0]   rsp_out_z,
   output logic                          rsp_blending,
   output logic [pta_pkg::TAG_W-1:0]     rsp_transition_count
);
   import pta_pkg::*;

   item_type   head;
   logic       head_valid;
   logic       pop;
   result_type res;
   logic       res_valid;
   logic       res_ready;
   result_type rsp_ff;
   logic       rsp_valid_ff;

   pta_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_joint_index    (req_joint_index),
      .req_angle_x        (req_angle_x),
      .req_angle_y        (req_angle_y),
      .req_angle_z        (req_angle_z),
      .req_sequence_tag   (req_sequence_tag),
      .req_motion_id      (req_motion_id),
      .req_elapsed_time   (req_elapsed_time),
      .req_blend_duration (req_blend_duration),
      .head               (head),
      .head_valid         (head_valid),
      .pop                (pop)
   );

   pta_back #(.JOINTS(JOINTS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .res        (res),
      .res_valid  (res_valid),
      .res_ready  (res_ready)
   );

   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_out_joint        = rsp_ff.out_joint;
   assign rsp_out_x            = rsp_ff.out_x;
   assign rsp_out_y            = rsp_ff.out_y;
   assign rsp_out_z            = rsp_ff.out_z;
   assign rsp_blending         = rsp_ff.blending;
   assign rsp_transition_count = rsp_ff.transition_count;

`ifndef SYNTHESIS
   a_blend_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_blending |-> ({1'b0, rsp_out_joint} < 7'(JOINTS)))
      else $error("blended result for joint outside the pose");

   a_engine_holds: assert property (@(posedge clock) disable iff (reset)
      res_valid && !res_ready |=> res_valid && $stable(res))
      else $error("engine result changed while output register full");

   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("engine popped an empty queue");
`endif

endmodule
